// ===== hdl/sliding_window_median_macros.svh =====
// assertion macros for the sliding window median block
// used by the rtl files that carry assertions; expects clk and rst_n in scope
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH
`ifndef SYNTHESIS
`define SWM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("swm assertion failed");
`define SWM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swm assertion failed");
`else
`define SWM_ASSERT(label, prop)
`define SWM_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ===== hdl/swm_pkg.sv =====
// shared types and constants of the sliding window median block
// no dependencies
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int DATA_W         = 32;
    localparam int OUT_W          = 33;
    localparam int CFG_W          = 7;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_RESULT
    } swm_state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_EVICT,
        OP_INSERT
    } swm_op_t;

    typedef struct packed {
        swm_op_t                   op;
        logic signed [DATA_W-1:0] sample;
    } swm_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/sliding_window_median.sv =====
// sliding window median: top level, control and config port; uses swm_pkg, swm_cell
// steps per word: accept, evict the oldest word while the window is full (repeated after the window
// shrinks), insert, then with a full window load the result, waiting while a held result is stalled
// a new word is not accepted until the previous one has finished these steps (in_stall is high)
// reset: rst_n asynchronous active low clears the fill count, handshake state and window_size
// (to 3); cell contents are left as they are and are never read before being written
`default_nettype none

module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // config port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire        [swm_pkg::PADDR_W-1:0] paddr,
    input  wire        [swm_pkg::PDATA_W-1:0] pwdata,
    output logic       [swm_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    // sample channel
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire signed [swm_pkg::DATA_W-1:0]  sample,
    input  wire                               restart,
    // result channel
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic signed [swm_pkg::OUT_W-1:0]  median_twice
);
    import swm_pkg::*;
`include "sliding_window_median_macros.svh"

    localparam int AGE_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    // config register
    logic [CFG_W-1:0] window_size_reg;
    logic             cfg_write;
    logic [CNT_W-1:0] eff_w;

    // control state
    swm_state_t               state_reg;
    swm_state_t               state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     window_full;
    logic signed [DATA_W-1:0] sample_reg;
    logic signed [DATA_W-1:0] sample_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [OUT_W-1:0]  median_reg;
    logic signed [OUT_W-1:0]  median_next;

    // cell row
    swm_cell_ctrl_t           cell_ctrl;
    logic signed [DATA_W-1:0] value_w [WINDOW_MAX];
    logic [AGE_W-1:0]         age_w [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]    ins_vec;
    logic [WINDOW_MAX-1:0]    hit_vec;
    logic [AGE_W-1:0]         oldest_age;
    logic [AGE_W-1:0]         evict_pos;

    // median readout
    logic [CNT_W-1:0]         lo_idx_full;
    logic [CNT_W-1:0]         hi_idx_full;
    logic signed [DATA_W-1:0] lo_value;
    logic signed [DATA_W-1:0] hi_value;
    logic signed [OUT_W-1:0]  median_sum;

    // ------------------------------------------------------------------
    // config port: one register, no wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            window_size_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW_SIZE)
        begin
            prdata = PDATA_W'(window_size_reg);
        end
    end

    // window length in use: zero counts as one, anything above the store depth is clipped
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            eff_w = CNT_W'(1);
        end
        else if (int'(window_size_reg) > WINDOW_MAX)
        begin
            eff_w = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_w = CNT_W'(window_size_reg);
        end
    end

    // ------------------------------------------------------------------
    // row of ordered cells; each cell sees its neighbours' value and age
    // ------------------------------------------------------------------

    // the oldest stored word carries age count-1
    assign oldest_age = AGE_W'(count_reg - CNT_W'(1));

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_value;
            logic [AGE_W-1:0]         left_age;
            logic                     left_ins;
            logic signed [DATA_W-1:0] right_value;
            logic [AGE_W-1:0]         right_age;

            if (gi == 0)
            begin : g_first
                // nothing to the left: a new word here always comes from the sample
                assign left_value = sample_reg;
                assign left_age   = '0;
                assign left_ins   = 1'b0;
            end
            else
            begin : g_inner_left
                assign left_value = value_w[gi-1];
                assign left_age   = age_w[gi-1];
                assign left_ins   = ins_vec[gi-1];
            end

            if (gi == WINDOW_MAX - 1)
            begin : g_last
                // top cell is beyond the fill count after any eviction
                assign right_value = value_w[gi];
                assign right_age   = age_w[gi];
            end
            else
            begin : g_inner_right
                assign right_value = value_w[gi+1];
                assign right_age   = age_w[gi+1];
            end

            swm_cell #(
                .IDX   (gi),
                .AGE_W (AGE_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .count       (count_reg),
                .oldest_age  (oldest_age),
                .evict_pos   (evict_pos),
                .left_value  (left_value),
                .left_age    (left_age),
                .left_ins    (left_ins),
                .right_value (right_value),
                .right_age   (right_age),
                .value       (value_w[gi]),
                .age         (age_w[gi]),
                .ins         (ins_vec[gi]),
                .hit         (hit_vec[gi])
            );
        end
    endgenerate

    // position of the oldest word; exactly one cell matches during an eviction
    always_comb
    begin
        evict_pos = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (hit_vec[i])
            begin
                evict_pos = evict_pos | AGE_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // median: sum of the cells at (w-1)/2 and w/2, which coincide for odd w
    // ------------------------------------------------------------------
    assign lo_idx_full = (eff_w - CNT_W'(1)) >> 1;
    assign hi_idx_full = eff_w >> 1;
    assign lo_value    = value_w[lo_idx_full[AGE_W-1:0]];
    assign hi_value    = value_w[hi_idx_full[AGE_W-1:0]];
    assign median_sum  = OUT_W'(lo_value) + OUT_W'(hi_value);

    // ------------------------------------------------------------------
    // sequencer: accept, evict the oldest while full, insert, then result
    // ------------------------------------------------------------------
    assign window_full = (count_reg >= eff_w);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        sample_next      = sample_reg;
        median_next      = median_reg;
        out_valid_next   = out_valid_reg && out_stall;
        cell_ctrl.op     = OP_HOLD;
        cell_ctrl.sample = sample_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    if (restart)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (window_full)
                begin
                    // window full: drop the oldest word, possibly several times after a shrink
                    cell_ctrl.op = OP_EVICT;
                    count_next   = count_reg - CNT_W'(1);
                end
                else
                begin
                    cell_ctrl.op = OP_INSERT;
                    count_next   = count_reg + CNT_W'(1);
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (count_reg == eff_w)
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || !out_stall)
                    begin
                        median_next    = median_sum;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // window still filling: no result word
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        median_reg <= median_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign median_twice = median_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SWM_ASSERT_IMPL(a_evict_single_oldest, state_reg == ST_SHIFT && window_full, $onehot(hit_vec))
    `SWM_ASSERT_IMPL(a_insert_ordered, state_reg == ST_SHIFT && !window_full, $onehot(ins_vec ^ (ins_vec << 1)))
    `SWM_ASSERT_IMPL(a_result_count, state_reg == ST_RESULT, count_reg != '0 && count_reg <= eff_w)
    `SWM_ASSERT_IMPL(a_result_source, $rose(out_valid_reg), $past(state_reg == ST_RESULT))

endmodule

`default_nettype wire

// ===== hdl/swm_cell.sv =====
// one cell of the ordered window store: a value and its age
// depends on swm_pkg
`default_nettype none

module swm_cell #(
    parameter int IDX   = 0,
    parameter int AGE_W = 6,
    parameter int CNT_W = 7
) (
    input  wire                               clk,
    input  swm_pkg::swm_cell_ctrl_t           ctrl,
    input  wire        [CNT_W-1:0]            count,
    input  wire        [AGE_W-1:0]            oldest_age,
    input  wire        [AGE_W-1:0]            evict_pos,
    input  wire signed [swm_pkg::DATA_W-1:0]  left_value,
    input  wire        [AGE_W-1:0]            left_age,
    input  wire                               left_ins,
    input  wire signed [swm_pkg::DATA_W-1:0]  right_value,
    input  wire        [AGE_W-1:0]            right_age,
    output logic signed [swm_pkg::DATA_W-1:0] value,
    output logic       [AGE_W-1:0]            age,
    output logic                              ins,
    output logic                              hit
);
    import swm_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic [AGE_W-1:0]         age_reg;
    logic [AGE_W-1:0]         age_next;
    logic                     in_use;

    assign in_use = CNT_W'(IDX) < count;
    assign ins    = in_use ? (ctrl.sample <= value_reg) : 1'b1;
    assign hit    = in_use && (age_reg == oldest_age);
    assign value  = value_reg;
    assign age    = age_reg;

    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        case (ctrl.op)
            OP_EVICT:
            begin
                // close the gap left by the oldest word
                if (AGE_W'(IDX) >= evict_pos)
                begin
                    value_next = right_value;
                    age_next   = right_age;
                end
            end
            OP_INSERT:
            begin
                if (ins)
                begin
                    if (left_ins)
                    begin
                        value_next = left_value;
                        age_next   = left_age + AGE_W'(1);
                    end
                    else
                    begin
                        value_next = ctrl.sample;
                        age_next   = '0;
                    end
                end
                else
                begin
                    age_next = age_reg + AGE_W'(1);
                end
            end
            default:
            begin
                value_next = value_reg;
                age_next   = age_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

`default_nettype wire
